// ===== rtl/core/imu_cal_pkg.sv =====
// Shared types, constants and tables for the IMU offset calibration and tilt unit.
`default_nettype none
package imu_cal_pkg;

    localparam int CAL_SAMPLES      = 1000;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int TABLE_LEN        = 24;
    localparam int CORDIC_STEPS     = (ANGLE_ITERATIONS < TABLE_LEN) ?
                                      ANGLE_ITERATIONS : TABLE_LEN;
    localparam int NUM_AXES         = 6;
    localparam int DIV_BITS         = 32;

    // offset averaging by reciprocal multiply, exact for any sum of CAL_SAMPLES readings
    localparam int CAL_MAG_BITS   = $clog2(CAL_SAMPLES * 32768 + 1);
    localparam int CAL_SHIFT      = CAL_MAG_BITS + $clog2(CAL_SAMPLES);
    localparam int CAL_RECIP_BITS = CAL_MAG_BITS + 1;
    localparam int CAL_PROD_BITS  = CAL_MAG_BITS + CAL_RECIP_BITS;
    localparam logic [63:0] CAL_RECIP_WIDE =
        ((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [CAL_RECIP_BITS-1:0] CAL_RECIP = CAL_RECIP_WIDE[CAL_RECIP_BITS-1:0];

    localparam logic [2:0] AXIS_AX = 3'd0;
    localparam logic [2:0] AXIS_AZ = 3'd2;
    localparam logic [2:0] AXIS_GX = 3'd3;
    localparam logic [2:0] AXIS_LAST = 3'(NUM_AXES - 1);

    localparam logic signed [31:0] HALF_TURN  = 32'sd5898240;
    localparam logic signed [15:0] TILT_LIMIT = 16'sd23040;

    localparam logic [1:0] ST_MEASURE = 2'd0;
    localparam logic [1:0] ST_SAMPLE  = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    localparam logic REG_GRAVITY = 1'b0;
    localparam logic REG_SENS    = 1'b1;

    localparam logic [14:0] GRAVITY_RESET = 15'd16384;
    localparam logic [7:0]  SENS_RESET    = 8'd131;

    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } sample_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] acc_x_corr;
        logic signed [15:0] acc_y_corr;
        logic signed [15:0] acc_z_corr;
        logic signed [15:0] gyr_x_corr;
        logic signed [15:0] gyr_y_corr;
        logic signed [15:0] gyr_z_corr;
        logic signed [15:0] tilt_angle;
        logic signed [15:0] pitch_rate;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       init;
        logic       cordic_step;
        logic       div_load_axis;
        logic       div_step;
        logic       store_rate;
        logic       store_offset;
        logic       clear_sums;
        logic       out_load;
        logic [2:0] axis;
        logic [4:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        logic cal_done;
    } dp_status_t;

    // atan(2^-i) in degrees scaled by 32768
    function automatic logic [20:0] atan_entry(input logic [4:0] i);
        logic [20:0] v;
        case (i)
            5'd0:  v = 21'd1474560;
            5'd1:  v = 21'd870484;
            5'd2:  v = 21'd459940;
            5'd3:  v = 21'd233473;
            5'd4:  v = 21'd117189;
            5'd5:  v = 21'd58652;
            5'd6:  v = 21'd29333;
            5'd7:  v = 21'd14667;
            5'd8:  v = 21'd7334;
            5'd9:  v = 21'd3667;
            5'd10: v = 21'd1833;
            5'd11: v = 21'd917;
            5'd12: v = 21'd458;
            5'd13: v = 21'd229;
            5'd14: v = 21'd115;
            5'd15: v = 21'd57;
            5'd16: v = 21'd29;
            5'd17: v = 21'd14;
            5'd18: v = 21'd7;
            5'd19: v = 21'd4;
            5'd20: v = 21'd2;
            5'd21: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/imu_cal_dp.sv =====
// Datapath: offset correction, calibration sums, CORDIC angle and serial divider.
`default_nettype none
module imu_cal_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire imu_cal_pkg::dp_cmd_t cmd,
    input  wire imu_cal_pkg::sample_t sample,
    input  wire logic [14:0]          gravity_counts,
    input  wire logic [7:0]           gyro_sensitivity,
    output imu_cal_pkg::dp_status_t   status,
    output imu_cal_pkg::result_t      result
);

    logic signed [15:0] offsets_reg [imu_cal_pkg::NUM_AXES];
    logic signed [31:0] sums_reg    [imu_cal_pkg::NUM_AXES];
    logic [15:0]        count_reg;
    logic               cal_done_reg;

    logic signed [15:0] corr_reg    [imu_cal_pkg::NUM_AXES];
    logic [1:0]         status_reg;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic               zero_reg;
    logic [15:0]        rem_reg, dvs_reg;
    logic [31:0]        quo_reg;
    logic               neg_reg;
    logic signed [15:0] rate_reg;
    imu_cal_pkg::result_t result_reg;

    logic signed [15:0] raw [imu_cal_pkg::NUM_AXES];
    logic [16:0]        count_inc;
    logic               cal_finish;

    always_comb
    begin
        raw[0] = sample.accel_x;
        raw[1] = sample.accel_y;
        raw[2] = sample.accel_z;
        raw[3] = sample.gyro_x;
        raw[4] = sample.gyro_y;
        raw[5] = sample.gyro_z;
        count_inc  = {1'b0, count_reg} + 17'd1;
        cal_finish = (count_inc >= 17'(imu_cal_pkg::CAL_SAMPLES));
    end

    // divider: one quotient bit per cycle
    logic [16:0] rem_shift, rem_sub;
    logic        rem_ge;
    logic [31:0] div_val, div_mag;
    logic [15:0] div_dvs;
    logic signed [31:0] quo_signed, offset_val;
    logic [imu_cal_pkg::CAL_PROD_BITS-1:0] cal_prod;
    logic [31:0] cal_quo;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[31]};
        rem_ge    = rem_shift >= {1'b0, dvs_reg};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        if (cmd.div_load_axis)
            div_val = sums_reg[cmd.axis];
        else
            div_val = {{9{corr_reg[imu_cal_pkg::AXIS_GX][15]}},
                       corr_reg[imu_cal_pkg::AXIS_GX], 7'd0};
        div_dvs    = (gyro_sensitivity == 8'd0) ? 16'd1 : {8'd0, gyro_sensitivity};
        div_mag    = div_val[31] ? (32'd0 - div_val) : div_val;
        // average the sum magnitude by multiplying with the rounded-up reciprocal
        cal_prod   = {{imu_cal_pkg::CAL_RECIP_BITS{1'b0}},
                      div_mag[imu_cal_pkg::CAL_MAG_BITS-1:0]} *
                     {{imu_cal_pkg::CAL_MAG_BITS{1'b0}}, imu_cal_pkg::CAL_RECIP};
        cal_quo    = 32'(cal_prod >> imu_cal_pkg::CAL_SHIFT);
        quo_signed = neg_reg ? $signed(32'd0 - quo_reg) : $signed(quo_reg);
        offset_val = quo_signed - ((cmd.axis == imu_cal_pkg::AXIS_AZ) ?
                                   $signed({17'd0, gravity_counts}) : 32'sd0);
    end

    // CORDIC init and step
    logic signed [31:0] x0, y0, dx, dy;
    logic [20:0]        tval;
    logic signed [31:0] zr, tilt_full;
    logic signed [15:0] tilt;
    logic signed [15:0] rate_val;

    always_comb
    begin
        x0   = {{8{corr_reg[imu_cal_pkg::AXIS_AZ][15]}}, corr_reg[imu_cal_pkg::AXIS_AZ], 8'd0};
        y0   = {{8{corr_reg[imu_cal_pkg::AXIS_AX][15]}}, corr_reg[imu_cal_pkg::AXIS_AX], 8'd0};
        dx   = y_reg >>> cmd.iter;
        dy   = x_reg >>> cmd.iter;
        tval = imu_cal_pkg::atan_entry(cmd.iter);
        zr   = z_reg + 32'sd128;
        tilt_full = zr >>> 8;
        if (zero_reg)
            tilt = 16'sd0;
        else if (tilt_full > 32'(imu_cal_pkg::TILT_LIMIT))
            tilt = imu_cal_pkg::TILT_LIMIT;
        else if (tilt_full < -32'(imu_cal_pkg::TILT_LIMIT))
            tilt = -imu_cal_pkg::TILT_LIMIT;
        else
            tilt = tilt_full[15:0];
        if (neg_reg)
            rate_val = (quo_reg > 32'd32768) ? 16'sh8000 : $signed(16'(32'd0 - quo_reg));
        else
            rate_val = (quo_reg > 32'd32767) ? 16'sh7fff : $signed(quo_reg[15:0]);
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < imu_cal_pkg::NUM_AXES; k++)
            begin
                offsets_reg[k] <= 16'sd0;
                sums_reg[k]    <= 32'sd0;
            end
            count_reg    <= 16'd0;
            cal_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cal_done_reg <= 1'b0;
                if (sample.opcode == imu_cal_pkg::OP_CALIBRATE)
                begin
                    for (int k = 0; k < imu_cal_pkg::NUM_AXES; k++)
                        sums_reg[k] <= sums_reg[k] + 32'(raw[k]);
                    cal_done_reg <= cal_finish;
                    count_reg    <= cal_finish ? 16'd0 : count_inc[15:0];
                end
            end
            if (cmd.store_offset)
                offsets_reg[cmd.axis] <= offset_val[15:0];
            if (cmd.clear_sums)
                for (int k = 0; k < imu_cal_pkg::NUM_AXES; k++)
                    sums_reg[k] <= 32'sd0;
        end
    end

    // per-item payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < imu_cal_pkg::NUM_AXES; k++)
                corr_reg[k] <= raw[k] - offsets_reg[k];
            if (sample.opcode == imu_cal_pkg::OP_CALIBRATE)
                status_reg <= cal_finish ? imu_cal_pkg::ST_DONE : imu_cal_pkg::ST_SAMPLE;
            else
                status_reg <= imu_cal_pkg::ST_MEASURE;
        end
        if (cmd.init)
        begin
            zero_reg <= (x0 == 32'sd0) && (y0 == 32'sd0);
            if (x0 < 0)
            begin
                z_reg <= (y0 >= 0) ? imu_cal_pkg::HALF_TURN : -imu_cal_pkg::HALF_TURN;
                x_reg <= -x0;
                y_reg <= -y0;
            end
            else
            begin
                z_reg <= 32'sd0;
                x_reg <= x0;
                y_reg <= y0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + $signed({11'd0, tval});
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - $signed({11'd0, tval});
            end
        end
        if (cmd.init)
        begin
            quo_reg <= div_mag;
            neg_reg <= div_val[31];
            rem_reg <= 16'd0;
            dvs_reg <= div_dvs;
        end
        else if (cmd.div_load_axis)
        begin
            quo_reg <= cal_quo;
            neg_reg <= div_val[31];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[15:0] : rem_shift[15:0];
            quo_reg <= {quo_reg[30:0], rem_ge};
        end
        if (cmd.store_rate)
            rate_reg <= rate_val;
        if (cmd.out_load)
        begin
            result_reg.status     <= status_reg;
            result_reg.acc_x_corr <= corr_reg[0];
            result_reg.acc_y_corr <= corr_reg[1];
            result_reg.acc_z_corr <= corr_reg[2];
            result_reg.gyr_x_corr <= corr_reg[3];
            result_reg.gyr_y_corr <= corr_reg[4];
            result_reg.gyr_z_corr <= corr_reg[5];
            result_reg.tilt_angle <= tilt;
            result_reg.pitch_rate <= rate_reg;
        end
    end

    assign status.cal_done = cal_done_reg;
    assign result          = result_reg;

endmodule
`default_nettype wire

// ===== rtl/core/imu_cal_ctrl.sv =====
// Controller: sequences load, CORDIC, divisions, offset update and output transfer.
`default_nettype none
module imu_cal_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    sample_valid,
    output logic                         sample_ready,
    output logic                         result_valid,
    input  wire logic                    result_ready,
    input  wire imu_cal_pkg::dp_status_t status,
    output imu_cal_pkg::dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_RUN, S_STORE_RATE, S_AX_LOAD, S_AX_STORE, S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] axis_reg, axis_next;
    logic       result_valid_reg, result_valid_next;
    logic       out_free;

    assign out_free     = !result_valid_reg || result_ready;
    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        axis_next         = axis_reg;
        result_valid_next = result_valid_reg && !result_ready;
        cmd               = '0;
        cmd.axis          = axis_reg;
        cmd.iter          = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                cnt_next   = 5'd0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.div_step    = 1'b1;
                cmd.cordic_step = ({1'b0, cnt_reg} < 6'(imu_cal_pkg::CORDIC_STEPS));
                cnt_next        = cnt_reg + 5'd1;
                if (cnt_reg == 5'(imu_cal_pkg::DIV_BITS - 1))
                    state_next = S_STORE_RATE;
            end
            S_STORE_RATE:
            begin
                cmd.store_rate = 1'b1;
                axis_next      = imu_cal_pkg::AXIS_AX;
                state_next     = status.cal_done ? S_AX_LOAD : S_FINISH;
            end
            S_AX_LOAD:
            begin
                cmd.div_load_axis = 1'b1;
                state_next        = S_AX_STORE;
            end
            S_AX_STORE:
            begin
                cmd.store_offset = 1'b1;
                if (axis_reg == imu_cal_pkg::AXIS_LAST)
                begin
                    cmd.clear_sums = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    axis_next  = axis_reg + 3'd1;
                    state_next = S_AX_LOAD;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.out_load      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= 5'd0;
            axis_reg         <= 3'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            axis_reg         <= axis_next;
            result_valid_reg <= result_valid_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> (state_reg == S_INIT))
        else $error("accepted transfer did not start processing");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register overwritten");

    a_one_phase_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.init, cmd.div_load_axis, cmd.store_rate,
                  cmd.store_offset, cmd.out_load}))
        else $error("conflicting datapath commands");

    a_offsets_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_offset |-> status.cal_done)
        else $error("offset written without finished calibration");

endmodule
`default_nettype wire

// ===== rtl/core/imu_offset_calibrate_tilt_unit.sv =====
// Top level: APB register file, controller and datapath of the IMU calibration and tilt unit.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  sample    | sample_valid, sample_ready, sample        | in
//  result    | result_valid, result_ready, result        | out
//  config    | psel, penable, pwrite, paddr, pwdata,     | in/out
//            | prdata, pready                            |
//
// After a transfer the unit runs init, the serial rate divider and the rate store, then
// loads the result and only then takes the next transfer; the item that ends a calibration
// run adds a load and a store step per axis for the six reciprocal-multiply offset averages.
// The 32-step serial rate divider sets the processing time; the CORDIC runs beside it.
// A new sample is taken once the result is in the output register, even while stalled.
// A stalled result holds the last item in its final state until the register frees.
// Reset clears offsets, sums, count and the configuration registers to their defaults at once.
`default_nettype none
module imu_offset_calibrate_tilt_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_ready,
    input  wire imu_cal_pkg::sample_t sample,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output imu_cal_pkg::result_t      result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [14:0] gravity_reg;
    logic [7:0]  sens_reg;
    logic        wr_en;

    imu_cal_pkg::dp_cmd_t    cmd;
    imu_cal_pkg::dp_status_t dp_status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= imu_cal_pkg::GRAVITY_RESET;
            sens_reg    <= imu_cal_pkg::SENS_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == imu_cal_pkg::REG_GRAVITY)
                gravity_reg <= pwdata[14:0];
            else
                sens_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == imu_cal_pkg::REG_SENS)
            prdata = {24'd0, sens_reg};
        else
            prdata = {17'd0, gravity_reg};
    end

    imu_cal_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (dp_status),
        .cmd          (cmd)
    );

    imu_cal_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sample           (sample),
        .gravity_counts   (gravity_reg),
        .gyro_sensitivity (sens_reg),
        .status           (dp_status),
        .result           (result)
    );

endmodule
`default_nettype wire
